// File: rtl/sv39_ptw_pkg.sv
// Shared types and constants for the Sv39 page table walker.
// Used by sv39_ptw_ctrl, sv39_ptw_dpath and the top level; no dependencies.
package sv39_ptw_pkg;

  localparam int VA_W        = 39;
  localparam int PPN_W       = 44;
  localparam int PA_W        = 56;
  localparam int ENTRY_W     = 64;
  localparam int IDX_W       = 12;
  localparam int OFFSET_W    = 12;
  localparam int VPN_W       = 9;
  localparam int TABLE_WORDS = 512;
  localparam int PPN_LSB     = 10;

  // item command codes
  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_XLATE = 1'b1;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_INVALID = 2'd1,
    ST_OUTSIDE = 2'd2
  } status_t;

  typedef logic [1:0] level_t;
  localparam level_t LEVEL_TOP  = 2'd2;
  localparam level_t LEVEL_MID  = 2'd1;
  localparam level_t LEVEL_LEAF = 2'd0;

  // controller -> datapath
  typedef struct packed {
    logic    clr_en;        // clearing pass writes one zero word
    logic    wr_en;         // store write transaction accepted
    logic    rd_start;      // translation accepted, read top-level entry
    logic    rd_next;       // read entry of the next level down
    logic    res_load_out;  // load output register from the live result
    logic    res_save;      // park the live result in the pending register
    logic    pend_load_out; // load output register from the pending register
    status_t res_code;
  } ptw_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic root_ok;
    logic entry_ok;
    logic next_ok;
    logic last_level;
    logic clear_done;
    logic out_free;
  } ptw_stat_t;

endpackage

// File: rtl/sv39_ptw_ctrl.sv
// Walk controller: one-hot state machine that sequences clear, store writes and walks.
// Depends on sv39_ptw_pkg.
module sv39_ptw_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic                   cmd,
  input  sv39_ptw_pkg::ptw_stat_t st,
  output sv39_ptw_pkg::ptw_cmd_t  ctl
);

  typedef enum logic [3:0] {
    S_CLEAR = 4'b0001,
    S_IDLE  = 4'b0010,
    S_CHECK = 4'b0100,
    S_HOLD  = 4'b1000
  } state_t;

  state_t state;
  state_t state_next;
  logic   walk_done;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    ctl          = '0;
    ctl.res_code = sv39_ptw_pkg::ST_OK;
    state_next   = state;
    in_stall     = 1'b1;
    walk_done    = 1'b0;
    case (state)
      S_CLEAR: begin
        ctl.clr_en = 1'b1;
        if (st.clear_done) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          if (cmd == sv39_ptw_pkg::CMD_XLATE) begin
            if (st.root_ok) begin
              ctl.rd_start = 1'b1;
              state_next   = S_CHECK;
            end else begin
              ctl.res_code = sv39_ptw_pkg::ST_OUTSIDE;
              ctl.res_save = 1'b1;
              state_next   = S_HOLD;
            end
          end else begin
            ctl.wr_en = 1'b1;
          end
        end
      end
      S_CHECK: begin
        walk_done = 1'b1;
        if (!st.entry_ok) begin
          ctl.res_code = sv39_ptw_pkg::ST_INVALID;
        end else if (st.last_level) begin
          ctl.res_code = sv39_ptw_pkg::ST_OK;
        end else if (!st.next_ok) begin
          ctl.res_code = sv39_ptw_pkg::ST_OUTSIDE;
        end else begin
          walk_done   = 1'b0;
          ctl.rd_next = 1'b1;
        end
        if (walk_done) begin
          if (st.out_free) begin
            ctl.res_load_out = 1'b1;
            state_next       = S_IDLE;
          end else begin
            ctl.res_save = 1'b1;
            state_next   = S_HOLD;
          end
        end
      end
      S_HOLD: begin
        if (st.out_free) begin
          ctl.pend_load_out = 1'b1;
          state_next        = S_IDLE;
        end
      end
      default: begin
        state_next = S_CLEAR;
      end
    endcase
  end

endmodule

// File: rtl/sv39_ptw_dpath.sv
// Walk datapath: table store, root register, walk registers and result registers.
// Depends on sv39_ptw_pkg; driven by sv39_ptw_ctrl.
module sv39_ptw_dpath #(
  parameter int STORE_WORDS = 4096
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  sv39_ptw_pkg::ptw_cmd_t                  ctl,
  output sv39_ptw_pkg::ptw_stat_t                 st,
  input  logic                                   cfg_wr_en,
  input  logic [sv39_ptw_pkg::PPN_W-1:0]         cfg_wr_data,
  input  logic [sv39_ptw_pkg::IDX_W-1:0]         word_index,
  input  logic [sv39_ptw_pkg::ENTRY_W-1:0]       entry_data,
  input  logic [sv39_ptw_pkg::VA_W-1:0]          virt_addr,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic [1:0]                             status,
  output logic [sv39_ptw_pkg::PA_W-1:0]          phys_addr
);

  localparam int AW          = $clog2(STORE_WORDS);
  localparam int PW          = (AW > sv39_ptw_pkg::VPN_W) ? AW - sv39_ptw_pkg::VPN_W : 1;
  localparam int TABLE_COUNT = STORE_WORDS / sv39_ptw_pkg::TABLE_WORDS;
  localparam int OFS         = sv39_ptw_pkg::OFFSET_W;
  localparam int VPN         = sv39_ptw_pkg::VPN_W;

  logic [sv39_ptw_pkg::ENTRY_W-1:0] mem [STORE_WORDS];

  logic [sv39_ptw_pkg::PPN_W-1:0]   root_page;
  logic [sv39_ptw_pkg::VA_W-1:0]    va;
  sv39_ptw_pkg::level_t             level;
  logic [sv39_ptw_pkg::ENTRY_W-1:0] rdata;
  logic [AW-1:0]                    clr_cnt;

  logic                             mem_we;
  logic [AW-1:0]                    mem_wa;
  logic [AW-1:0]                    mem_ra;
  logic [sv39_ptw_pkg::ENTRY_W-1:0] mem_wd;
  logic [31:0]                      idx_ext;
  logic                             idx_ok;

  logic [sv39_ptw_pkg::PPN_W-1:0]   next_page;
  logic [sv39_ptw_pkg::PPN_W-1:0]   rd_page;
  logic [VPN-1:0]                   rd_slot;
  logic [PW+VPN-1:0]                rd_full;

  logic [sv39_ptw_pkg::PA_W-1:0]    live_pa;
  sv39_ptw_pkg::status_t            pend_status;
  logic [sv39_ptw_pkg::PA_W-1:0]    pend_pa;
  sv39_ptw_pkg::status_t            out_status;
  logic                             out_valid_next;

  assign next_page = rdata[sv39_ptw_pkg::PPN_LSB +: sv39_ptw_pkg::PPN_W];

  // store write port: clearing pass or input write
  assign idx_ext = 32'(word_index);
  assign idx_ok  = idx_ext < 32'(STORE_WORDS);
  assign mem_we  = ctl.clr_en | (ctl.wr_en & idx_ok);
  assign mem_wa  = ctl.clr_en ? clr_cnt : idx_ext[AW-1:0];
  assign mem_wd  = ctl.clr_en ? '0 : entry_data;

  // read address: table page times 512 plus the level's index bits
  assign rd_page = ctl.rd_start ? root_page : next_page;

  always_comb begin
    if (ctl.rd_start) begin
      rd_slot = virt_addr[OFS+2*VPN +: VPN];
    end else begin
      case (level)
        sv39_ptw_pkg::LEVEL_TOP: rd_slot = va[OFS+VPN +: VPN];
        sv39_ptw_pkg::LEVEL_MID: rd_slot = va[OFS +: VPN];
        default:                 rd_slot = va[OFS +: VPN];
      endcase
    end
  end

  assign rd_full = {rd_page[PW-1:0], rd_slot};
  assign mem_ra  = rd_full[AW-1:0];

  assign live_pa = (ctl.res_code == sv39_ptw_pkg::ST_OK) ?
                   {next_page, va[OFS-1:0]} : '0;

  assign st.root_ok    = root_page < sv39_ptw_pkg::PPN_W'(TABLE_COUNT);
  assign st.next_ok    = next_page < sv39_ptw_pkg::PPN_W'(TABLE_COUNT);
  assign st.entry_ok   = rdata[0];
  assign st.last_level = level == sv39_ptw_pkg::LEVEL_LEAF;
  assign st.clear_done = clr_cnt == AW'(STORE_WORDS - 1);
  assign st.out_free   = !out_valid || !out_stall;

  assign out_valid_next = (ctl.res_load_out | ctl.pend_load_out) ? 1'b1 :
                          (out_valid & out_stall);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (ctl.rd_start | ctl.rd_next) begin
      rdata <= mem[mem_ra];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      root_page <= '0;
      clr_cnt   <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        root_page <= cfg_wr_data;
      end
      if (ctl.clr_en) begin
        clr_cnt <= clr_cnt + 1'b1;
      end
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.rd_start) begin
      va    <= virt_addr;
      level <= sv39_ptw_pkg::LEVEL_TOP;
    end else if (ctl.rd_next) begin
      level <= level - 1'b1;
    end
    if (ctl.res_save) begin
      pend_status <= ctl.res_code;
      pend_pa     <= live_pa;
    end
    if (ctl.res_load_out) begin
      out_status <= ctl.res_code;
      phys_addr  <= live_pa;
    end else if (ctl.pend_load_out) begin
      out_status <= pend_status;
      phys_addr  <= pend_pa;
    end
  end

  assign status = out_status;

endmodule

// File: rtl/sv39_page_table_walk_core.sv
// Sv39 page table walker top level: controller plus datapath.
// Depends on sv39_ptw_pkg, sv39_ptw_ctrl and sv39_ptw_dpath.
//
// Usage: input transactions (in_valid/in_stall) carry cmd, word_index,
// entry_data and virt_addr. cmd write stores entry_data at word_index
// (ignored at or past STORE_WORDS) and gives no result; the block stays
// idle, so input is not stalled after it. cmd translate walks up to three
// levels from the root page and returns one result transaction
// (out_valid/out_stall) with status and phys_addr. Each level is one
// dependent entry read from the single store read port, data registered;
// input is stalled until the walk ends and its result is registered at
// the output or parked in the pending register. The root is written
// through cfg_wr_en/cfg_wr_data; the user must do so only while idle,
// which the block itself does not enforce. Reset: root returns to 0 and
// a clearing pass zeroes the store, one word a cycle, with in_stall high.
// If the receiver stalls, the current result holds at the output and a
// finished walk waits in a pending register; input is stalled meanwhile.
module sv39_page_table_walk_core #(
  parameter int STORE_WORDS = 4096
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_wr_en,
  input  logic [sv39_ptw_pkg::PPN_W-1:0]     cfg_wr_data,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic                               cmd,
  input  logic [sv39_ptw_pkg::IDX_W-1:0]     word_index,
  input  logic [sv39_ptw_pkg::ENTRY_W-1:0]   entry_data,
  input  logic [sv39_ptw_pkg::VA_W-1:0]      virt_addr,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [1:0]                         status,
  output logic [sv39_ptw_pkg::PA_W-1:0]      phys_addr
);

  sv39_ptw_pkg::ptw_cmd_t  ctl;
  sv39_ptw_pkg::ptw_stat_t st;

  sv39_ptw_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .cmd      (cmd),
    .st       (st),
    .ctl      (ctl)
  );

  sv39_ptw_dpath #(
    .STORE_WORDS (STORE_WORDS)
  ) u_dpath (
    .clk         (clk),
    .rst         (rst),
    .ctl         (ctl),
    .st          (st),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .word_index  (word_index),
    .entry_data  (entry_data),
    .virt_addr   (virt_addr),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .status      (status),
    .phys_addr   (phys_addr)
  );

endmodule

// File: rtl/sv39_ptw_checker.sv
// Port-level checks for sv39_page_table_walk_core, attached by bind.
// Depends on sv39_ptw_pkg.
module sv39_ptw_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           in_valid,
  input logic                           in_stall,
  input logic                           cmd,
  input logic                           out_valid,
  input logic                           out_stall,
  input logic [1:0]                     status,
  input logic [sv39_ptw_pkg::PA_W-1:0]  phys_addr
);

  // a stalled result transaction holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(status) && $stable(phys_addr))
    else $error("result changed while stalled");

  // faults carry a zero address
  a_fault_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != sv39_ptw_pkg::ST_OK |-> phys_addr == '0)
    else $error("fault result with nonzero address");

  // the clearing pass blocks input right after reset
  a_clear_stall: assert property (@(posedge clk)
    rst |=> in_stall)
    else $error("input taken during clearing pass");

  // one translation at a time
  a_walk_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && cmd == sv39_ptw_pkg::CMD_XLATE |=> in_stall)
    else $error("input taken while a walk is in flight");

endmodule

bind sv39_page_table_walk_core sv39_ptw_checker u_sv39_ptw_checker (.*);

// File: sim/sv39_page_table_walk_core_tb.sv
// Self-checking testbench for sv39_page_table_walk_core: directed table, then random walks.
// Keeps its own copy of the store and root page to predict each untyped translation.
// Depends on sv39_ptw_pkg and the core RTL only.
module sv39_page_table_walk_core_tb;
  import sv39_ptw_pkg::*;

  localparam int STORE_WORDS = 4096;
  localparam logic [PPN_W-1:0] TABLES = PPN_W'(STORE_WORDS / TABLE_WORDS);
  localparam int CYCLE_LIMIT = 400000;
  localparam int SETTLE_CYCLES = 8;

  typedef struct packed {
    logic               cmd;
    logic [IDX_W-1:0]   widx;
    logic [ENTRY_W-1:0] data;
    logic [VA_W-1:0]    va;
    logic               typed_exp;  // expectation written into the table row
    status_t            exp_st;
    logic [PA_W-1:0]    exp_pa;
  } walk_item_t;

  typedef struct packed {
    status_t         st;
    logic [PA_W-1:0] pa;
  } xlate_result_t;

  typedef enum int {RX_OPEN, RX_LIGHT, RX_HEAVY} rx_mode_t;

  // vpn2 = 5, vpn1 = 3, vpn0 = 7
  localparam logic [VA_W-1:0] VA_A  = {9'd5, 9'd3, 9'd7, 12'hABC};
  localparam logic [VA_W-1:0] VA_A0 = {9'd5, 9'd3, 9'd7, 12'h000};
  localparam logic [ENTRY_W-1:0] ONES = '1;
  localparam logic [VA_W-1:0] VA_ONES = '1;

  // walk for VA_A: table 0 slot 5 -> table 1 slot 3 (word 515) -> table 2 slot 7 (word 1031)
  localparam int N_DIRECTED = 25;
  localparam walk_item_t DIRECTED [N_DIRECTED] = '{
    '{CMD_XLATE, 12'd0,    64'd0, 39'd0,   1'b1, ST_INVALID, 56'd0},
    '{CMD_XLATE, 12'hFFF,  ONES,  VA_ONES, 1'b1, ST_INVALID, 56'd0},
    '{CMD_WRITE, 12'd5,    64'h401, VA_ONES, 1'b0, ST_OK, 56'd0},
    '{CMD_WRITE, 12'd515,  64'h801, 39'd0,   1'b0, ST_OK, 56'd0},
    '{CMD_WRITE, 12'd1031, ONES,    39'd0,   1'b0, ST_OK, 56'd0},
    '{CMD_XLATE, 12'd0,    64'd0, VA_A,    1'b1, ST_OK, 56'hFF_FFFF_FFFF_FABC},
    '{CMD_WRITE, 12'd1031, 64'hFFFF_FFFF_FFFF_FFFE, 39'd0, 1'b0, ST_OK, 56'd0},
    '{CMD_XLATE, 12'd0,    64'd0, VA_A,    1'b1, ST_INVALID, 56'd0},
    '{CMD_WRITE, 12'd1031, 64'h1,   39'd0,   1'b0, ST_OK, 56'd0},
    '{CMD_XLATE, 12'hFFF,  ONES,  VA_A,    1'b1, ST_OK, 56'hABC},
    '{CMD_WRITE, 12'd515,  64'h2001, 39'd0,  1'b0, ST_OK, 56'd0},
    '{CMD_XLATE, 12'd0,    64'd0, VA_A,    1'b1, ST_OUTSIDE, 56'd0},
    '{CMD_WRITE, 12'd515,  ONES,    39'd0,   1'b0, ST_OK, 56'd0},
    '{CMD_XLATE, 12'd0,    64'd0, VA_A,    1'b1, ST_OUTSIDE, 56'd0},
    '{CMD_WRITE, 12'd515,  64'hFFC0_0000_0000_0BFF, 39'd0, 1'b0, ST_OK, 56'd0},
    '{CMD_WRITE, 12'd1031, 64'h0123_4567_89AB_CDEF, 39'd0, 1'b0, ST_OK, 56'd0},
    '{CMD_XLATE, 12'd0,    64'd0, VA_A,    1'b0, ST_OK, 56'd0},
    '{CMD_XLATE, 12'hABC,  64'd5, VA_A0,   1'b0, ST_OK, 56'd0},
    '{CMD_WRITE, 12'd515,  64'h800, 39'd0,   1'b0, ST_OK, 56'd0},
    '{CMD_XLATE, 12'd0,    64'd0, VA_A,    1'b1, ST_INVALID, 56'd0},
    '{CMD_WRITE, 12'd5,    64'h2001, 39'd0,  1'b0, ST_OK, 56'd0},
    '{CMD_XLATE, 12'd0,    64'd0, VA_A,    1'b1, ST_OUTSIDE, 56'd0},
    '{CMD_WRITE, 12'd0,    ONES,    39'd0,   1'b0, ST_OK, 56'd0},
    '{CMD_XLATE, 12'd0,    64'd0, 39'd0,   1'b1, ST_OUTSIDE, 56'd0},
    '{CMD_WRITE, 12'd4095, 64'h1,   VA_ONES, 1'b0, ST_OK, 56'd0}
  };

  logic                clk;
  logic                rst = 1'b1;
  logic                cfg_wr_en = 1'b0;
  logic [PPN_W-1:0]    cfg_wr_data = '0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic                cmd = CMD_WRITE;
  logic [IDX_W-1:0]    word_index = '0;
  logic [ENTRY_W-1:0]  entry_data = '0;
  logic [VA_W-1:0]     virt_addr = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [1:0]          status;
  logic [PA_W-1:0]     phys_addr;

  logic [ENTRY_W-1:0]  table_mirror [STORE_WORDS];
  logic [PPN_W-1:0]    root_mirror = '0;
  walk_item_t          item_fifo [$];
  xlate_result_t       expected_xlates [$];
  walk_item_t          cur_item;
  xlate_result_t       got_exp;

  int n_queued = 0;
  int n_accepted = 0;
  int n_writes = 0;
  int n_xlates = 0;
  int n_checked = 0;
  int n_roots = 0;
  int errors = 0;
  int cycles = 0;
  int gap_left = 0;
  int burst_left = 1;
  int rx_left = 0;
  rx_mode_t rx_mode = RX_OPEN;

  sv39_page_table_walk_core #(.STORE_WORDS(STORE_WORDS)) dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .cmd         (cmd),
    .word_index  (word_index),
    .entry_data  (entry_data),
    .virt_addr   (virt_addr),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .status      (status),
    .phys_addr   (phys_addr)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [ENTRY_W-1:0] rand64();
    return {32'($urandom), 32'($urandom)};
  endfunction

  function automatic logic [VA_W-1:0] rand_va();
    return {7'($urandom), 32'($urandom)};
  endfunction

  function automatic logic [PPN_W-1:0] rand_page();
    return {12'($urandom), 32'($urandom)};
  endfunction

  // three-level walk over the mirrored store
  function automatic xlate_result_t walk_tables(input logic [VA_W-1:0] va);
    xlate_result_t r;
    logic [PPN_W-1:0] page;
    logic [ENTRY_W-1:0] pte;
    logic [VPN_W-1:0] slot;
    page = root_mirror;
    r.st = ST_OK;
    r.pa = '0;
    for (int lvl = 2; lvl >= 0; lvl--) begin
      if (page >= TABLES) begin
        r.st = ST_OUTSIDE;
        return r;
      end
      slot = va[OFFSET_W + VPN_W * lvl +: VPN_W];
      pte = table_mirror[int'(page) * TABLE_WORDS + int'(slot)];
      if (!pte[0]) begin
        r.st = ST_INVALID;
        return r;
      end
      page = pte[PPN_LSB +: PPN_W];
    end
    r.pa = {page, va[OFFSET_W-1:0]};
    return r;
  endfunction

  function automatic logic [IDX_W-1:0] table_slot(input logic [PPN_W-1:0] page,
                                                  input logic [VPN_W-1:0] vpn);
    return IDX_W'(int'(page) * TABLE_WORDS + int'(vpn));
  endfunction

  // mostly an in-store table, sometimes the first page past the store or a wild one
  function automatic logic [PPN_W-1:0] pick_table();
    int pick;
    pick = $urandom_range(0, 15);
    if (pick == 0) return TABLES;
    if (pick == 1) return rand_page();
    return PPN_W'($urandom_range(0, int'(TABLES) - 1));
  endfunction

  // random permission and upper bits; valid bit clear now and then
  function automatic logic [ENTRY_W-1:0] make_pte(input logic [PPN_W-1:0] page);
    return {10'($urandom), page, 9'($urandom), 1'($urandom_range(0, 15) != 0)};
  endfunction

  task automatic queue_item(input walk_item_t it);
    item_fifo.push_back(it);
    n_queued++;
  endtask

  task automatic queue_write(input logic [IDX_W-1:0] idx, input logic [ENTRY_W-1:0] data);
    queue_item('{CMD_WRITE, idx, data, rand_va(), 1'b0, ST_OK, '0});
  endtask

  task automatic queue_xlate(input logic [VA_W-1:0] va);
    queue_item('{CMD_XLATE, IDX_W'($urandom), rand64(), va, 1'b0, ST_OK, '0});
  endtask

  // mostly complete three-level chains with random content, plus stray writes and lookups
  task automatic queue_walks(input int n_items);
    int start;
    int kind;
    logic [VA_W-1:0] va;
    logic [PPN_W-1:0] mid_pg;
    logic [PPN_W-1:0] leaf_pg;
    start = n_queued;
    while (n_queued - start < n_items) begin
      kind = $urandom_range(0, 9);
      va = rand_va();
      if (kind < 7 && root_mirror < TABLES) begin
        mid_pg = pick_table();
        leaf_pg = pick_table();
        queue_write(table_slot(root_mirror, va[38:30]), make_pte(mid_pg));
        if (mid_pg < TABLES) queue_write(table_slot(mid_pg, va[29:21]), make_pte(leaf_pg));
        if (leaf_pg < TABLES) queue_write(table_slot(leaf_pg, va[20:12]), make_pte(rand_page()));
        queue_xlate(va);
        if ($urandom_range(0, 2) == 0) begin
          va[OFFSET_W-1:0] = OFFSET_W'($urandom);
          queue_xlate(va);
        end
      end else if (kind[0]) begin
        queue_write(IDX_W'($urandom), rand64());
      end else begin
        queue_xlate(va);
      end
    end
  endtask

  task automatic drain();
    do @(negedge clk);
    while (n_accepted != n_queued || expected_xlates.size() != 0);
    // a trailing store write gives no result; let it land
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_root(input logic [PPN_W-1:0] v);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    root_mirror = v;
    n_roots++;
  endtask

  task automatic apply_item(input walk_item_t it);
    xlate_result_t r;
    n_accepted++;
    if (it.cmd == CMD_WRITE) begin
      n_writes++;
      if (int'(it.widx) < STORE_WORDS) table_mirror[it.widx] = it.data;
    end else begin
      n_xlates++;
      r = walk_tables(it.va);
      if (it.typed_exp) begin
        r.st = it.exp_st;
        r.pa = it.exp_pa;
      end
      expected_xlates.push_back(r);
    end
  endtask

  // sender: bursts of random length separated by random gaps
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) apply_item(cur_item);
      if (!in_valid || !in_stall) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (item_fifo.size() > 0) begin
          cur_item = item_fifo.pop_front();
          cmd <= cur_item.cmd;
          word_index <= cur_item.widx;
          entry_data <= cur_item.data;
          virt_addr <= cur_item.va;
          in_valid <= 1'b1;
          burst_left--;
          if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 16);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver: checks each result transaction and stalls in changing modes
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (expected_xlates.size() == 0) begin
        $display("%0t: unexpected result: expected none, actual status %0d phys_addr %h",
                 $time, status, phys_addr);
        errors++;
      end else begin
        got_exp = expected_xlates.pop_front();
        n_checked++;
        if (status !== got_exp.st) begin
          $display("%0t: status mismatch: expected %0d, actual %0d", $time, got_exp.st, status);
          errors++;
        end
        if (phys_addr !== got_exp.pa) begin
          $display("%0t: phys_addr mismatch: expected %h, actual %h",
                   $time, got_exp.pa, phys_addr);
          errors++;
        end
      end
    end
    if (rx_left == 0) begin
      rx_mode = rx_mode_t'($urandom_range(0, 2));
      rx_left = $urandom_range(20, 80);
    end else begin
      rx_left--;
    end
    case (rx_mode)
      RX_OPEN:  out_stall <= 1'b0;
      RX_LIGHT: out_stall <= ($urandom_range(0, 2) == 0);
      default:  out_stall <= ($urandom_range(0, 3) != 0);
    endcase
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("%0t: timeout, %0d results still outstanding", $time, expected_xlates.size());
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    logic [PPN_W-1:0] roots [5];
    foreach (table_mirror[i]) table_mirror[i] = '0;
    roots[0] = PPN_W'(7);
    roots[1] = '1;
    roots[2] = TABLES;
    roots[3] = PPN_W'($urandom_range(1, 6));
    roots[4] = '0;

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // root stays at its reset value for the directed rows
    for (int i = 0; i < N_DIRECTED; i++) queue_item(DIRECTED[i]);
    drain();

    foreach (roots[i]) begin
      set_root(roots[i]);
      queue_walks((roots[i] < TABLES) ? 165 : 20);
      drain();
    end

    $display("Run covered %0d store writes and %0d translations over %0d root settings,",
             n_writes, n_xlates, n_roots + 1);
    $display("with %0d translation results compared and %0d mismatches.", n_checked, errors);
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
